>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is high
`define CHECK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, masked while reset is high
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hw/rtl/mmat_pkg.sv
package mmat_pkg;

   localparam int DATA_W  = 24;
   localparam int CHAN_W  = 4;
   localparam int TREND_W = 2;

   localparam logic [TREND_W-1:0] TREND_EQUAL = 2'd0;
   localparam logic [TREND_W-1:0] TREND_ROSE  = 2'd1;
   localparam logic [TREND_W-1:0] TREND_FELL  = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [DATA_W-1:0] sample;
      logic              bad;
   } item_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  out_channel;
      logic [DATA_W-1:0]  out_sample;
      logic [TREND_W-1:0] sample_trend;
      logic [DATA_W-1:0]  average;
      logic [TREND_W-1:0] average_trend;
      logic               bad_channel;
   } result_type;

   function automatic logic [TREND_W-1:0] trend_of(input logic [DATA_W-1:0] now_v,
                                                   input logic [DATA_W-1:0] prev_v);
      logic [TREND_W-1:0] code;
      if (now_v > prev_v) begin
         code = TREND_ROSE;
      end else if (now_v < prev_v) begin
         code = TREND_FELL;
      end else begin
         code = TREND_EQUAL;
      end
      return code;
   endfunction

endpackage

>>> hw/rtl/mmat_ram.sv
module mmat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

>>> hw/rtl/mmat_front.sv
module mmat_front import mmat_pkg::*; #(
   parameter int CHANNELS = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAN_W-1:0] req_channel,
   input  logic [DATA_W-1:0] req_sample,
   input  logic              q_full,
   output logic              q_push,
   output item_type          q_item
);

   logic     front_valid_ff, front_valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign req_stall = front_valid_ff && q_full;
   assign q_push    = front_valid_ff && !q_full;
   assign accept    = req_valid && !req_stall;
   assign q_item    = item_ff;

   always_comb begin
      front_valid_in = front_valid_ff;
      item_in        = item_ff;
      if (accept) begin
         front_valid_in  = 1'b1;
         item_in.channel = req_channel;
         item_in.sample  = req_sample;
         // flag channels past the last one; the back end leaves state alone for them
         item_in.bad     = 32'(req_channel) >= 32'(CHANNELS);
      end else if (q_push) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

>>> hw/rtl/mmat_queue.sv
module mmat_queue import mmat_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     pop_valid,
   output item_type pop_item
);

   item_type            store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hw/rtl/mmat_back.sv
module mmat_back import mmat_pkg::*; #(
   parameter int CHANNELS = 11,
   parameter int WINDOW   = 5,
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
   localparam int FILL_W    = $clog2(WINDOW + 1),
   localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1,
   localparam int SUM_W     = DATA_W + $clog2(WINDOW),
   localparam int ST_W      = 2 * DATA_W + SUM_W + SLOT_W + FILL_W,
   localparam int WIN_DEPTH = CHANNELS * WINDOW,
   localparam int WA_W      = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  item_type          q_item,
   output logic              q_pop,
   output logic              st_re,
   output logic [CH_W-1:0]   st_raddr,
   input  logic [ST_W-1:0]   st_rdata,
   output logic              st_we,
   output logic [CH_W-1:0]   st_waddr,
   output logic [ST_W-1:0]   st_wdata,
   output logic              win_re,
   output logic [WA_W-1:0]   win_raddr,
   input  logic [DATA_W-1:0] win_rdata,
   output logic              win_we,
   output logic [WA_W-1:0]   win_waddr,
   output logic [DATA_W-1:0] win_wdata,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output result_type        rsp_data
);

   localparam int SLOT_CW = SLOT_W + 1;
   localparam int CNT_W   = $clog2(SUM_W);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_STATE = 3'd1;
   localparam logic [2:0] ST_WIN   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CHANNELS-1:0] ch_valid_ff, ch_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff, rsp_in;

   item_type            item_ff, item_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   logic                live_ff, live_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [DATA_W-1:0]   lsmp_ff, lsmp_in;
   logic [DATA_W-1:0]   lavg_ff, lavg_in;
   logic [WA_W-1:0]     waddr_ff, waddr_in;
   logic [FILL_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic [ST_W-1:0]     st_word;
   logic [FILL_W-1:0]   rd_fill;
   logic [SLOT_W-1:0]   rd_slot;
   logic [SLOT_W-1:0]   slot_clamp;
   logic [WA_W-1:0]     win_addr;
   logic                full;
   logic [DATA_W-1:0]   sub_v;
   logic [SUM_W-1:0]    sum_next;
   logic [FILL_W-1:0]   fill_next;
   logic [SLOT_CW-1:0]  slot_inc;
   logic [SLOT_W-1:0]   slot_next;
   logic [FILL_W:0]     trial;
   logic [FILL_W:0]     diff;
   logic                ge;
   logic [DATA_W-1:0]   mean;
   logic                out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // state word: {last average, last sample, sum, slot, fill}; unwritten channels read as zero
   assign st_word    = live_ff ? st_rdata : '0;
   assign rd_fill    = st_word[FILL_W-1:0];
   assign rd_slot    = st_word[FILL_W +: SLOT_W];
   assign slot_clamp = ({1'b0, rd_slot} >= SLOT_CW'(WINDOW)) ? '0 : rd_slot;
   assign win_addr   = WA_W'(32'(ch_ff) * 32'(WINDOW) + 32'(slot_clamp));

   assign full      = fill_ff >= FILL_W'(WINDOW);
   assign sub_v     = full ? win_rdata : '0;
   assign sum_next  = sum_ff - SUM_W'(sub_v) + SUM_W'(item_ff.sample);
   assign fill_next = full ? FILL_W'(WINDOW) : fill_ff + FILL_W'(1);
   assign slot_inc  = {1'b0, slot_ff} + SLOT_CW'(1);
   assign slot_next = (slot_inc >= SLOT_CW'(WINDOW)) ? '0 : slot_inc[SLOT_W-1:0];

   // one quotient bit per cycle, divisor is the fill count
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, fill_ff};
   assign ge    = trial >= {1'b0, fill_ff};
   assign mean  = quo_ff[DATA_W-1:0];

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign st_raddr  = CH_W'(q_item.channel);
   assign win_raddr = win_addr;
   assign win_waddr = waddr_ff;
   assign win_wdata = item_ff.sample;
   assign st_waddr  = ch_ff;
   assign st_wdata  = {mean, item_ff.sample, sum_ff, slot_ff, fill_ff};

   always_comb begin
      state_in     = state_ff;
      ch_valid_in  = ch_valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      item_in      = item_ff;
      ch_in        = ch_ff;
      live_in      = live_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      sum_in       = sum_ff;
      lsmp_in      = lsmp_ff;
      lavg_in      = lavg_ff;
      waddr_in     = waddr_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      q_pop        = 1'b0;
      st_re        = 1'b0;
      st_we        = 1'b0;
      win_re       = 1'b0;
      win_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               ch_in   = CH_W'(q_item.channel);
               if (q_item.bad) begin
                  state_in = ST_DONE;
               end else begin
                  st_re    = 1'b1;
                  live_in  = ch_valid_ff[CH_W'(q_item.channel)];
                  state_in = ST_STATE;
               end
            end
         end
         ST_STATE: begin
            fill_in  = rd_fill;
            slot_in  = slot_clamp;
            sum_in   = st_word[FILL_W + SLOT_W +: SUM_W];
            lsmp_in  = st_word[FILL_W + SLOT_W + SUM_W +: DATA_W];
            lavg_in  = st_word[ST_W-1 -: DATA_W];
            waddr_in = win_addr;
            win_re   = 1'b1;
            state_in = ST_WIN;
         end
         ST_WIN: begin
            // drop the oldest sample once the window is full, then add the new one
            sum_in   = sum_next;
            fill_in  = fill_next;
            slot_in  = slot_next;
            win_we   = 1'b1;
            rem_in   = '0;
            quo_in   = sum_next;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.out_channel  = item_ff.channel;
               rsp_in.out_sample   = item_ff.sample;
               rsp_in.bad_channel  = item_ff.bad;
               if (item_ff.bad) begin
                  rsp_in.sample_trend  = TREND_EQUAL;
                  rsp_in.average       = '0;
                  rsp_in.average_trend = TREND_EQUAL;
               end else begin
                  rsp_in.sample_trend  = trend_of(item_ff.sample, lsmp_ff);
                  rsp_in.average       = mean;
                  rsp_in.average_trend = trend_of(mean, lavg_ff);
                  st_we                = 1'b1;
                  ch_valid_in[ch_ff]   = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_valid_ff  <= ch_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      item_ff  <= item_in;
      ch_ff    <= ch_in;
      live_ff  <= live_in;
      fill_ff  <= fill_in;
      slot_ff  <= slot_in;
      sum_ff   <= sum_in;
      lsmp_ff  <= lsmp_in;
      lavg_ff  <= lavg_in;
      waddr_ff <= waddr_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
   end

endmodule

>>> hw/rtl/multichannel_moving_average_trend.sv
// channel  dir  handshake             beat fields
// req      in   req_valid, req_stall  req_channel, req_sample
// rsp      out  rsp_valid, rsp_stall  rsp_out_channel, rsp_out_sample, rsp_sample_trend,
//                                     rsp_average, rsp_average_trend, rsp_bad_channel
//
// A valid channel steps through the back end's IDLE, STATE, WIN, DIV and DONE states,
// with the bit-per-cycle divider in DIV; a rejected channel goes from IDLE to DONE.
// The front register and a two-beat queue take new beats while the back end works.
// Reset clears the per-channel valid bits, so every channel starts with zero state; the
// window memory is not cleared. A stalled result holds in the output register until taken.
`include "assert_macros.svh"

module multichannel_moving_average_trend import mmat_pkg::*; #(
   parameter int CHANNELS = 11,
   parameter int WINDOW   = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CHAN_W-1:0]  req_channel,
   input  logic [DATA_W-1:0]  req_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAN_W-1:0]  rsp_out_channel,
   output logic [DATA_W-1:0]  rsp_out_sample,
   output logic [TREND_W-1:0] rsp_sample_trend,
   output logic [DATA_W-1:0]  rsp_average,
   output logic [TREND_W-1:0] rsp_average_trend,
   output logic               rsp_bad_channel
);

   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int FILL_W    = $clog2(WINDOW + 1);
   localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W     = DATA_W + $clog2(WINDOW);
   localparam int ST_W      = 2 * DATA_W + SUM_W + SLOT_W + FILL_W;
   localparam int WIN_DEPTH = CHANNELS * WINDOW;
   localparam int WA_W      = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

   logic              q_full;
   logic              q_push;
   item_type          q_push_item;
   logic              q_pop;
   logic              q_valid;
   item_type          q_pop_item;
   logic              st_re, st_we;
   logic [CH_W-1:0]   st_raddr, st_waddr;
   logic [ST_W-1:0]   st_rdata, st_wdata;
   logic              win_re, win_we;
   logic [WA_W-1:0]   win_raddr, win_waddr;
   logic [DATA_W-1:0] win_rdata, win_wdata;
   result_type        rsp_data;
   logic              rsp_chan_out_of_range;
   logic              rsp_fields_zero;

   mmat_front #(.CHANNELS(CHANNELS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_channel (req_channel),
      .req_sample  (req_sample),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (q_push_item)
   );

   mmat_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_pop_item)
   );

   mmat_ram #(.WIDTH(ST_W), .DEPTH(CHANNELS)) u_state_ram (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .re    (st_re),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   mmat_ram #(.WIDTH(DATA_W), .DEPTH(WIN_DEPTH)) u_window_ram (
      .clock (clock),
      .we    (win_we),
      .waddr (win_waddr),
      .wdata (win_wdata),
      .re    (win_re),
      .raddr (win_raddr),
      .rdata (win_rdata)
   );

   mmat_back #(.CHANNELS(CHANNELS), .WINDOW(WINDOW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_pop_item),
      .q_pop     (q_pop),
      .st_re     (st_re),
      .st_raddr  (st_raddr),
      .st_rdata  (st_rdata),
      .st_we     (st_we),
      .st_waddr  (st_waddr),
      .st_wdata  (st_wdata),
      .win_re    (win_re),
      .win_raddr (win_raddr),
      .win_rdata (win_rdata),
      .win_we    (win_we),
      .win_waddr (win_waddr),
      .win_wdata (win_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_channel   = rsp_data.out_channel;
   assign rsp_out_sample    = rsp_data.out_sample;
   assign rsp_sample_trend  = rsp_data.sample_trend;
   assign rsp_average       = rsp_data.average;
   assign rsp_average_trend = rsp_data.average_trend;
   assign rsp_bad_channel   = rsp_data.bad_channel;

   assign rsp_chan_out_of_range = 32'(rsp_out_channel) >= 32'(CHANNELS);
   assign rsp_fields_zero       = (rsp_average == '0) && (rsp_sample_trend == TREND_EQUAL) &&
                                  (rsp_average_trend == TREND_EQUAL);

   `CHECK_IMPLY(a_push_not_full, clock, reset, q_push, !q_full)
   `CHECK_IMPLY(a_pop_has_beat, clock, reset, q_pop, q_valid)
   `CHECK_NEXT(a_push_fills_queue, clock, reset, q_push, q_valid)
   `CHECK_IMPLY(a_bad_flag_range, clock, reset, rsp_valid, rsp_bad_channel == rsp_chan_out_of_range)
   `CHECK_IMPLY(a_bad_zeroed, clock, reset, rsp_valid && rsp_bad_channel, rsp_fields_zero)

endmodule

>>> sim/multichannel_moving_average_trend_tb.sv
`timescale 1ns / 1ps

module multichannel_moving_average_trend_tb;
   import mmat_pkg::*;

   localparam int NUM_CHANNELS = 11;
   localparam int AVG_WINDOW   = 5;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CHAN_W-1:0]  req_channel = '0;
   logic [DATA_W-1:0]  req_sample = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [CHAN_W-1:0]  rsp_out_channel;
   logic [DATA_W-1:0]  rsp_out_sample;
   logic [TREND_W-1:0] rsp_sample_trend;
   logic [DATA_W-1:0]  rsp_average;
   logic [TREND_W-1:0] rsp_average_trend;
   logic               rsp_bad_channel;

   // per-channel window state mirrored from the block
   logic [DATA_W-1:0] win_samples [NUM_CHANNELS][AVG_WINDOW];
   logic [2:0]        win_fill [NUM_CHANNELS];
   logic [2:0]        win_slot [NUM_CHANNELS];
   logic [26:0]       win_sum [NUM_CHANNELS];
   logic [DATA_W-1:0] prev_sample [NUM_CHANNELS];
   logic [DATA_W-1:0] prev_average [NUM_CHANNELS];

   result_type pending_averages[$];
   int         mismatches = 0;
   int         send_idle_pct = 0;
   int         stall_pct = 0;

   multichannel_moving_average_trend uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_channel       (req_channel),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_out_sample    (rsp_out_sample),
      .rsp_sample_trend  (rsp_sample_trend),
      .rsp_average       (rsp_average),
      .rsp_average_trend (rsp_average_trend),
      .rsp_bad_channel   (rsp_bad_channel)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   function automatic logic [TREND_W-1:0] compare_trend(input logic [DATA_W-1:0] now_v,
                                                         input logic [DATA_W-1:0] old_v);
      if (now_v > old_v) begin
         return TREND_ROSE;
      end else if (now_v < old_v) begin
         return TREND_FELL;
      end
      return TREND_EQUAL;
   endfunction

   function automatic result_type moving_average_of(input logic [CHAN_W-1:0] ch,
                                                    input logic [DATA_W-1:0] smp);
      result_type  res;
      logic [2:0]  slot;
      logic [26:0] mean_wide;
      res.out_channel = ch;
      res.out_sample  = smp;
      if (ch >= NUM_CHANNELS) begin
         res.sample_trend  = TREND_EQUAL;
         res.average       = '0;
         res.average_trend = TREND_EQUAL;
         res.bad_channel   = 1'b1;
         return res;
      end
      slot = win_slot[ch];
      // drop the oldest sample once the window is full
      if (win_fill[ch] >= AVG_WINDOW) begin
         win_sum[ch] = win_sum[ch] - win_samples[ch][slot];
      end else begin
         win_fill[ch] = win_fill[ch] + 3'd1;
      end
      win_samples[ch][slot] = smp;
      win_sum[ch] = win_sum[ch] + smp;
      win_slot[ch] = (slot == AVG_WINDOW - 1) ? 3'd0 : slot + 3'd1;
      mean_wide = win_sum[ch] / win_fill[ch];
      res.sample_trend  = compare_trend(smp, prev_sample[ch]);
      res.average       = mean_wide[DATA_W-1:0];
      res.average_trend = compare_trend(res.average, prev_average[ch]);
      res.bad_channel   = 1'b0;
      prev_sample[ch]  = smp;
      prev_average[ch] = res.average;
      return res;
   endfunction

   // check every result beat against the oldest prediction
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_averages.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result beat: ch %0d sample %h avg %h",
                        rsp_out_channel, rsp_out_sample, rsp_average);
            end
         end else begin
            want = pending_averages.pop_front();
            if (rsp_out_channel !== want.out_channel || rsp_out_sample !== want.out_sample ||
                rsp_sample_trend !== want.sample_trend || rsp_average !== want.average ||
                rsp_average_trend !== want.average_trend ||
                rsp_bad_channel !== want.bad_channel) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp ch %0d smp %h st %0d avg %h at %0d bad %0b",
                           want.out_channel, want.out_sample, want.sample_trend,
                           want.average, want.average_trend, want.bad_channel);
                  $display("         got ch %0d smp %h st %0d avg %h at %0d bad %0b",
                           rsp_out_channel, rsp_out_sample, rsp_sample_trend,
                           rsp_average, rsp_average_trend, rsp_bad_channel);
               end
            end
         end
      end
   end

   // leave valid high on return so back-to-back beats need no extra edge
   task automatic send_beat(input logic [CHAN_W-1:0] ch, input logic [DATA_W-1:0] smp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_channel <= ch;
      req_sample  <= smp;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pending_averages.push_back(moving_average_of(ch, smp));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_averages.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_corner_samples();
      send_beat(4'd0, 24'h000000);
      send_beat(4'd0, 24'hFFFFFF);
      send_beat(4'd0, 24'hFFFFFF);
      send_beat(4'd0, 24'hFFFFFF);
      send_beat(4'd0, 24'hFFFFFF);
      send_beat(4'd0, 24'hFFFFFF);
      // window full: wrap and subtract the oldest
      send_beat(4'd0, 24'hFFFFFF);
      send_beat(4'd0, 24'h000001);
      send_beat(4'd10, 24'h800000);
      send_beat(4'd10, 24'h800000);
      send_beat(4'd10, 24'h000001);
      for (int i = 1; i <= 7; i++) begin
         send_beat(4'd5, 24'(i));
      end
   endtask

   task automatic test_rejected_channels();
      send_beat(4'd11, 24'hFFFFFF);
      send_beat(4'd15, 24'h123456);
      send_beat(4'd12, 24'h000000);
      send_beat(4'd14, 24'hAAAAAA);
      send_beat(4'd10, 24'h555555);
   endtask

   task automatic test_random_stream(input int n);
      logic [CHAN_W-1:0] ch;
      logic [DATA_W-1:0] smp;
      int                pick;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 8) begin
            ch = 4'($urandom_range(11, 15));
         end else begin
            ch = 4'($urandom_range(0, NUM_CHANNELS - 1));
         end
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            smp = 24'($urandom);
         end else if (pick < 50) begin
            smp = 24'($urandom_range(0, 255));
         end else if (pick < 75 && ch < NUM_CHANNELS) begin
            // hold or nudge the channel's last sample to hit equal trends
            smp = prev_sample[ch] + 24'($urandom_range(0, 2)) - 24'd1;
            if (pick < 62) begin
               smp = prev_sample[ch];
            end
         end else if (pick < 88) begin
            smp = 24'hFFFFFF - 24'($urandom_range(0, 255));
         end else begin
            smp = 24'($urandom_range(24'h7FFF00, 24'h8000FF));
         end
         send_beat(ch, smp);
      end
   endtask

   initial begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         win_fill[c]     = '0;
         win_slot[c]     = '0;
         win_sum[c]      = '0;
         prev_sample[c]  = '0;
         prev_average[c] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 27;
      stall_pct     = 73;
      test_corner_samples();
      test_rejected_channels();
      drain_results();
      test_random_stream(670);
      drain_results();

      send_idle_pct = 73;
      stall_pct     = 27;
      test_random_stream(670);
      drain_results();

      send_idle_pct = 0;
      stall_pct     = 0;
      test_random_stream(670);
      drain_results();

      // catch any stray beat after the last expected one
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_averages.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
